// ----- rtl/assert_macros.svh -----
// Assertion macros used by the checker file of the parser block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, switched off while reset is high.
`define ASSERT_CLK(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("assertion failed");

// Clocked check of an implication, switched off while reset is high.
`define ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

`endif

// ----- rtl/ccfp_pkg.sv -----
// Types, constants and helpers shared by the line field parser modules.
package ccfp_pkg;

  typedef enum logic [1:0] {
    KIND_DATA = 2'd0,
    KIND_FEND = 2'd1,
    KIND_LEND = 2'd2,
    KIND_ERR  = 2'd3
  } kind_t;

  // Configuration register indexes.
  localparam logic [2:0] REG_MODE_CSV    = 3'd0;
  localparam logic [2:0] REG_DELIMITER   = 3'd1;
  localparam logic [2:0] REG_QUOTE       = 3'd2;
  localparam logic [2:0] REG_NULL_LENGTH = 3'd3;
  localparam logic [2:0] REG_NULL_BYTES  = 3'd4;
  localparam logic [2:0] REG_FIELD_LIMIT = 3'd5;

  localparam int unsigned CFG_DATA_W = 64;
  localparam int unsigned NUM_W      = 7;

  // Most fields taken from one line, whatever field_limit holds.
  localparam logic [NUM_W-1:0] FIELD_SLOTS = 7'd64;

  // Register reset values.
  localparam logic       RST_MODE_CSV    = 1'b0;
  localparam logic [7:0] RST_DELIMITER   = 8'd9;
  localparam logic [7:0] RST_QUOTE       = 8'd34;
  localparam logic [3:0] RST_NULL_LENGTH = 4'd0;
  localparam logic [63:0] RST_NULL_BYTES = 64'd0;
  localparam logic [6:0] RST_FIELD_LIMIT = 7'd64;

  localparam logic [7:0] CH_BACKSLASH = 8'h5C;
  localparam logic [7:0] CH_N = 8'h6E;
  localparam logic [7:0] CH_T = 8'h74;
  localparam logic [7:0] CH_R = 8'h72;
  localparam logic [7:0] CH_B = 8'h62;
  localparam logic [7:0] CH_F = 8'h66;
  localparam logic [7:0] CH_V = 8'h76;

  typedef struct packed {
    logic        mode_csv;
    logic [7:0]  delimiter_char;
    logic [7:0]  quote_char;
    logic [3:0]  null_length;
    logic [63:0] null_bytes;
    logic [6:0]  field_limit;
  } cfg_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] data;
    logic [5:0] field_index;
    logic       field_null;
    logic [6:0] field_count;
    logic       last;
  } res_t;

  // Results of one accepted item: how many, then up to two of them.
  typedef struct packed {
    logic [1:0] n;
    res_t       r0;
    res_t       r1;
  } push_t;

  function automatic logic [7:0] unescape(input logic [7:0] b);
    logic [7:0] r;
    unique case (b)
      CH_N:    r = 8'h0A;
      CH_T:    r = 8'h09;
      CH_R:    r = 8'h0D;
      CH_B:    r = 8'h08;
      CH_F:    r = 8'h0C;
      CH_V:    r = 8'h0B;
      default: r = b;
    endcase
    return r;
  endfunction

endpackage

// ----- rtl/ccfp_cfg.sv -----
// Configuration register file of the line field parser.
module ccfp_cfg (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              wr_en,
  input  logic [2:0]                        wr_index,
  input  logic [ccfp_pkg::CFG_DATA_W-1:0]   wr_data,
  output ccfp_pkg::cfg_t                    cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.mode_csv       <= ccfp_pkg::RST_MODE_CSV;
      cfg.delimiter_char <= ccfp_pkg::RST_DELIMITER;
      cfg.quote_char     <= ccfp_pkg::RST_QUOTE;
      cfg.null_length    <= ccfp_pkg::RST_NULL_LENGTH;
      cfg.null_bytes     <= ccfp_pkg::RST_NULL_BYTES;
      cfg.field_limit    <= ccfp_pkg::RST_FIELD_LIMIT;
    end else if (wr_en) begin
      unique case (wr_index)
        ccfp_pkg::REG_MODE_CSV:    cfg.mode_csv       <= wr_data[0];
        ccfp_pkg::REG_DELIMITER:   cfg.delimiter_char <= wr_data[7:0];
        ccfp_pkg::REG_QUOTE:       cfg.quote_char     <= wr_data[7:0];
        ccfp_pkg::REG_NULL_LENGTH: cfg.null_length    <= wr_data[3:0];
        ccfp_pkg::REG_NULL_BYTES:  cfg.null_bytes     <= wr_data;
        ccfp_pkg::REG_FIELD_LIMIT: cfg.field_limit    <= wr_data[6:0];
        default: begin
        end
      endcase
    end
  end

endmodule

// ----- rtl/ccfp_parse.sv -----
// Parser state and per-byte decode, producing up to two results per item.
module ccfp_parse #(
  parameter int FIELD_LEN  = 256,
  parameter int NULL_MAX   = 8
) (
  input  logic            clk,
  input  logic            rst,
  input  ccfp_pkg::cfg_t  cfg,
  input  logic            in_fire,
  input  logic [7:0]      ch,
  input  logic            line_end,
  output ccfp_pkg::push_t push
);

  localparam int LW = $clog2(FIELD_LEN);

  typedef enum logic [2:0] {
    ST_START  = 3'd0,
    ST_PLAIN  = 3'd1,
    ST_ESC    = 3'd2,
    ST_QUOTED = 3'd3,
    ST_QSEEN  = 3'd4,
    ST_SKIP   = 3'd5
  } state_t;

  state_t                        st, st_next;
  logic [LW-1:0]                 len, len_next;
  logic [ccfp_pkg::NUM_W-1:0]    num, num_next, num1, lim;
  logic                          match, match_next;
  logic [3:0]                    nlen;
  logic [7:0]                    ab;
  logic                          a_ovf, a_miss, a_match;
  logic [LW-1:0]                 a_len;
  logic                          null_cur, null_add, s_match;
  logic                          is_delim, is_quote, is_bs, csv;
  logic [1:0]                    n;
  ccfp_pkg::res_t                r0, r1;
  logic                          do_add;

  function automatic ccfp_pkg::res_t mk(input ccfp_pkg::kind_t k, input logic [7:0] d,
                                        input logic [ccfp_pkg::NUM_W-1:0] idx,
                                        input logic nul,
                                        input logic [ccfp_pkg::NUM_W-1:0] cnt);
    ccfp_pkg::res_t r;
    r.kind        = k;
    r.data        = d;
    r.field_index = idx[5:0];
    r.field_null  = nul;
    r.field_count = cnt;
    r.last        = 1'b0;
    return r;
  endfunction

  assign nlen = (int'(cfg.null_length) > NULL_MAX) ? 4'(NULL_MAX) : cfg.null_length;
  assign lim  = (cfg.field_limit > ccfp_pkg::FIELD_SLOTS) ? ccfp_pkg::FIELD_SLOTS
                                                          : cfg.field_limit;
  assign num1 = num + 1'b1;
  assign csv      = cfg.mode_csv;
  assign is_delim = (ch == cfg.delimiter_char);
  assign is_quote = (ch == cfg.quote_char);
  assign is_bs    = (ch == ccfp_pkg::CH_BACKSLASH);

  // Byte that an add at the current position would append.
  always_comb begin
    if (st == ST_ESC) begin
      ab = line_end ? ccfp_pkg::CH_BACKSLASH : ccfp_pkg::unescape(ch);
    end else begin
      ab = ch;
    end
  end

  assign a_ovf    = (len == LW'(FIELD_LEN - 1));
  assign a_miss   = (len >= LW'(nlen)) || (cfg.null_bytes[{len[2:0], 3'b000} +: 8] != ab);
  assign a_match  = match & ~a_miss;
  assign a_len    = len + 1'b1;
  assign null_cur = (nlen != 4'd0) && match && (len == LW'(nlen));
  assign null_add = (nlen != 4'd0) && a_match && (a_len == LW'(nlen));
  assign s_match  = (nlen != 4'd0) && (cfg.null_bytes[7:0] == ch);

  always_comb begin
    st_next    = st;
    len_next   = len;
    num_next   = num;
    match_next = match;
    n          = 2'd0;
    r0         = '0;
    r1         = '0;
    do_add     = 1'b0;
    if (!line_end) begin
      unique case (st)
        ST_START: begin
          if (num >= lim) begin
          end else if (csv && is_quote) begin
            st_next = ST_QUOTED;
          end else if (is_delim) begin
            r0 = mk(ccfp_pkg::KIND_FEND, 8'd0, num, null_cur, '0);
            n = 2'd1;
            num_next = num1; len_next = '0; match_next = 1'b1; st_next = ST_START;
          end else if (!csv && is_bs) begin
            st_next = ST_ESC;
          end else begin
            st_next = ST_PLAIN;
            do_add = 1'b1;
          end
        end
        ST_PLAIN: begin
          if (is_delim) begin
            r0 = mk(ccfp_pkg::KIND_FEND, 8'd0, num, null_cur, '0);
            n = 2'd1;
            num_next = num1; len_next = '0; match_next = 1'b1; st_next = ST_START;
          end else if (!csv && is_bs) begin
            st_next = ST_ESC;
          end else begin
            do_add = 1'b1;
          end
        end
        ST_ESC: begin
          st_next = ST_PLAIN;
          do_add = 1'b1;
        end
        ST_QUOTED: begin
          if (is_quote) begin
            st_next = ST_QSEEN;
          end else begin
            do_add = 1'b1;
          end
        end
        ST_QSEEN: begin
          if (is_quote) begin
            st_next = ST_QUOTED;
            do_add = 1'b1;
          end else begin
            // Close the field; any byte but the delimiter also opens the next, while the field limit allows another.
            r0 = mk(ccfp_pkg::KIND_FEND, 8'd0, num, null_cur, '0);
            n = 2'd1;
            num_next = num1; len_next = '0; match_next = 1'b1; st_next = ST_START;
            if (is_delim || num1 >= lim) begin
            end else if (!csv && is_bs) begin
              st_next = ST_ESC;
            end else begin
              st_next = ST_PLAIN;
              r1 = mk(ccfp_pkg::KIND_DATA, ch, num1, 1'b0, '0);
              n = 2'd2;
              len_next = LW'(1);
              match_next = s_match;
            end
          end
        end
        default: begin
        end
      endcase
      if (do_add) begin
        n = 2'd1;
        if (a_ovf) begin
          st_next = ST_SKIP;
          r0 = mk(ccfp_pkg::KIND_ERR, 8'd0, num, 1'b0, '0);
        end else begin
          len_next = a_len;
          match_next = a_match;
          r0 = mk(ccfp_pkg::KIND_DATA, ab, num, 1'b0, '0);
        end
      end
    end else begin
      // Every line end returns the parser to the start of a line.
      st_next = ST_START; len_next = '0; num_next = '0; match_next = 1'b1;
      unique case (st)
        ST_START: begin
          n = 2'd1;
          if (num < lim) begin
            r0 = mk(ccfp_pkg::KIND_LEND, 8'd0, num, null_cur, num1);
          end else begin
            r0 = mk(ccfp_pkg::KIND_LEND, 8'd0, '0, 1'b0, num);
          end
        end
        ST_PLAIN, ST_QSEEN: begin
          n = 2'd1;
          r0 = mk(ccfp_pkg::KIND_LEND, 8'd0, num, null_cur, num1);
        end
        ST_ESC: begin
          if (a_ovf) begin
            n = 2'd1;
            r0 = mk(ccfp_pkg::KIND_ERR, 8'd0, num, 1'b0, '0);
          end else begin
            n = 2'd2;
            r0 = mk(ccfp_pkg::KIND_DATA, ab, num, 1'b0, '0);
            r1 = mk(ccfp_pkg::KIND_LEND, 8'd0, num, null_add, num1);
          end
        end
        ST_QUOTED: begin
          n = 2'd1;
          r0 = mk(ccfp_pkg::KIND_ERR, 8'd0, num, 1'b0, '0);
        end
        default: begin
        end
      endcase
    end
    if (n == 2'd1) begin
      r0.last = 1'b1;
    end
    if (n == 2'd2) begin
      r1.last = 1'b1;
    end
  end

  assign push.n  = in_fire ? n : 2'd0;
  assign push.r0 = r0;
  assign push.r1 = r1;

  always_ff @(posedge clk) begin
    if (rst) begin
      st    <= ST_START;
      len   <= '0;
      num   <= '0;
      match <= 1'b1;
    end else if (in_fire) begin
      st    <= st_next;
      len   <= len_next;
      num   <= num_next;
      match <= match_next;
    end
  end

endmodule

// ----- rtl/ccfp_outq.sv -----
// Result queue: takes up to two results a cycle, hands out one.
module ccfp_outq (
  input  logic            clk,
  input  logic            rst,
  input  ccfp_pkg::push_t push,
  input  logic            pop,
  output logic            room,
  output logic            head_valid,
  output ccfp_pkg::res_t  head
);

  localparam int DEPTH = 4;
  localparam int PW    = $clog2(DEPTH);

  ccfp_pkg::res_t mem [DEPTH];
  logic [PW-1:0]  rd_ptr, wr_ptr, wr_ptr1;
  logic [PW:0]    count;

  assign wr_ptr1    = wr_ptr + 1'b1;
  assign head_valid = (count != '0);
  assign head       = mem[rd_ptr];
  // Keep two free slots so any item can be taken.
  assign room       = (count <= (PW + 1)'(DEPTH - 2));

  always_ff @(posedge clk) begin
    if (push.n != 2'd0) begin
      mem[wr_ptr] <= push.r0;
    end
    if (push.n == 2'd2) begin
      mem[wr_ptr1] <= push.r1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= '0;
      wr_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + PW'(push.n);
      rd_ptr <= rd_ptr + PW'(pop);
      count  <= count + (PW + 1)'(push.n) - (PW + 1)'(pop);
    end
  end

endmodule

// ----- rtl/copy_line_field_parser.sv -----
// Top level of the line field parser: config registers, parser, result queue.
//
// Input channel: one item per handshake (in_valid high, in_stall low at the
// clock edge). An item is either one line byte on ch, or an end-of-line mark
// with line_end high. Output channel: one result per handshake (out_valid high,
// out_stall low), carrying kind, data, field_index, field_null, field_count
// and last; last marks the final result an item caused. An item causes zero,
// one or two results.
// Results of an item enter the result queue at the acceptance edge and show on
// the output right after it, so the first one can be taken at the next edge.
// Throughput: one item per cycle while in_stall is low; an item that causes
// two results hands them out one per output handshake.
// Stall: in_stall rises when the four-entry result queue has fewer than two
// free slots, so a stalled receiver holds the input once three results wait.
// Reset: configuration returns to its defaults (text format, tab delimiter,
// double-quote, null detection off, 64 fields), the queue empties and the
// parser waits at the start of a line. Write configuration only while idle.
module copy_line_field_parser #(
  parameter int FIELD_LEN  = 256,
  parameter int NULL_MAX   = 8
) (
  input  logic                            clk,
  input  logic                            rst,
  // configuration write port
  input  logic                            wr_en,
  input  logic [2:0]                      wr_index,
  input  logic [ccfp_pkg::CFG_DATA_W-1:0] wr_data,
  // input items
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [7:0]                      ch,
  input  logic                            line_end,
  // result items
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [1:0]                      kind,
  output logic [7:0]                      data,
  output logic [5:0]                      field_index,
  output logic                            field_null,
  output logic [6:0]                      field_count,
  output logic                            last
);

  ccfp_pkg::cfg_t  cfg;
  ccfp_pkg::push_t push;
  ccfp_pkg::res_t  head;
  logic            in_fire, room, pop;

  // Take an item only when the queue can absorb two results.
  assign in_stall = ~room;
  assign in_fire  = in_valid & ~in_stall;
  assign pop      = out_valid & ~out_stall;

  ccfp_cfg u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data),
    .cfg      (cfg)
  );

  ccfp_parse #(
    .FIELD_LEN  (FIELD_LEN),
    .NULL_MAX   (NULL_MAX)
  ) u_parse (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .in_fire  (in_fire),
    .ch       (ch),
    .line_end (line_end),
    .push     (push)
  );

  ccfp_outq u_outq (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .pop        (pop),
    .room       (room),
    .head_valid (out_valid),
    .head       (head)
  );

  // Drive the result fields straight from the queue head.
  assign kind        = head.kind;
  assign data        = head.data;
  assign field_index = head.field_index;
  assign field_null  = head.field_null;
  assign field_count = head.field_count;
  assign last        = head.last;

endmodule

// ----- rtl/ccfp_checker.sv -----
// Port-level checks of the line field parser and their binding.
`include "assert_macros.svh"

module ccfp_checker (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_stall,
  input logic [1:0] kind,
  input logic [7:0] data,
  input logic [5:0] field_index,
  input logic       field_null,
  input logic [6:0] field_count,
  input logic       last
);

  `ASSERT_CLK(a_out_hold, clk, rst, (out_valid && out_stall) |=> out_valid)
  `ASSERT_CLK(a_out_stable, clk, rst, (out_valid && out_stall) |=> ($stable(kind) && $stable(data) && $stable(field_index) && $stable(last)))
  `ASSERT_IMPL(a_data_clean, clk, rst, out_valid && (kind == ccfp_pkg::KIND_DATA), (field_count == 7'd0) && !field_null)
  `ASSERT_IMPL(a_end_last, clk, rst, out_valid && ((kind == ccfp_pkg::KIND_LEND) || (kind == ccfp_pkg::KIND_ERR)), last)

endmodule

bind copy_line_field_parser ccfp_checker u_ccfp_checker (
  .clk         (clk),
  .rst         (rst),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .kind        (kind),
  .data        (data),
  .field_index (field_index),
  .field_null  (field_null),
  .field_count (field_count),
  .last        (last)
);
